// ===== hdl/cbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsb_pkg: shared types and codes of the CB-prefix shift and bit unit
// Word layouts of the request and response channels, action codes, opcode
// group codes, shift selectors and the memory operand index.
// ----------------------------------------------------------------------------
package cbsb_pkg;

	// Action codes of a request word.
	typedef enum logic [1:0] {
		ACT_EXEC     = 2'd0,
		ACT_LOAD_REG = 2'd1,
		ACT_LOAD_FLG = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	// Opcode groups, taken from opcode bits 7..6.
	typedef enum logic [1:0] {
		GRP_SHIFT = 2'd0,
		GRP_BIT   = 2'd1,
		GRP_RES   = 2'd2,
		GRP_SET   = 2'd3
	} group_t;

	// Shift and rotate selectors, taken from opcode bits 5..3.
	typedef enum logic [2:0] {
		SH_RLC  = 3'd0,
		SH_RRC  = 3'd1,
		SH_RL   = 3'd2,
		SH_RR   = 3'd3,
		SH_SLA  = 3'd4,
		SH_SRA  = 3'd5,
		SH_SWAP = 3'd6,
		SH_SRL  = 3'd7
	} shift_sel_t;

	// Operand codes with a fixed meaning.
	localparam logic [2:0] OPND_H   = 3'd4;
	localparam logic [2:0] OPND_L   = 3'd5;
	localparam logic [2:0] OPND_MEM = 3'd6;

	localparam int unsigned REG_COUNT = 8;

	// Request word.
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] opcode;
		logic [7:0] mem_in;
		logic [2:0] reg_index;
		logic [7:0] reg_value;
	} req_word_t;

	// Response word.
	typedef struct packed {
		logic [7:0]  result;
		logic [2:0]  dest_index;
		logic        reg_write;
		logic        mem_write;
		logic [15:0] mem_addr;
		logic        zero_flag;
		logic        subtract_flag;
		logic        half_carry_flag;
		logic        carry_flag;
	} rsp_word_t;

	// Flag set, Z N H C.
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

// ===== hdl/cbsb_chan_if.sv =====
// ----------------------------------------------------------------------------
// cbsb_chan_if: valid/ready channel
// Carries one word per handshake; the word type is set at instantiation.
// ----------------------------------------------------------------------------
interface cbsb_chan_if #(
	parameter type payload_t = cbsb_pkg::req_word_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/cb_prefix_shift_bit_unit.sv =====
// ----------------------------------------------------------------------------
// cb_prefix_shift_bit_unit: CB-prefix shift, rotate and bit operations
// The response word of a taken request is registered in the output buffer before it is offered.
// Throughput: one request word per cycle while the skid word is empty, set by the
// single pass through the operand select, shifter and flag logic into the output register.
// A two-word output buffer lets a request be taken while a response waits.
// Reset clears the register file and the flags and empties the output buffer at once.
// ----------------------------------------------------------------------------
module cb_prefix_shift_bit_unit (
	input  logic             clk,
	input  logic             arst_n,
	cbsb_chan_if.sink        req,
	cbsb_chan_if.source      rsp
);

	// Architectural state.
	logic [7:0]       rf_q [cbsb_pkg::REG_COUNT];
	cbsb_pkg::flags_t flags_q;

	// Output buffer: main word and skid word.
	cbsb_pkg::rsp_word_t main_q;
	cbsb_pkg::rsp_word_t skid_q;
	logic                main_vld_q;
	logic                skid_vld_q;

	// Next state and response of the word being taken.
	logic [7:0]          rf_d [cbsb_pkg::REG_COUNT];
	cbsb_pkg::flags_t    flags_d;
	cbsb_pkg::rsp_word_t word_d;

	logic push;
	logic pop;

	assign req.ready = ~skid_vld_q;
	assign push      = req.valid & req.ready;
	assign pop       = main_vld_q & rsp.ready;
	assign rsp.valid = main_vld_q;
	assign rsp.payload = main_q;

	// Execute one request word against the current state.
	always_comb begin
		logic [2:0] opnd;
		logic [1:0] grp;
		logic [2:0] sel;
		logic [7:0] mask;
		logic [7:0] v;
		logic [7:0] r;
		logic       cout;

		rf_d    = rf_q;
		flags_d = flags_q;
		word_d  = '0;
		opnd    = req.payload.opcode[2:0];
		grp     = req.payload.opcode[7:6];
		sel     = req.payload.opcode[5:3];
		mask    = 8'(1) << sel;
		v       = (opnd == cbsb_pkg::OPND_MEM) ? req.payload.mem_in : rf_q[opnd];
		r       = v;
		cout    = 1'b0;

		case (cbsb_pkg::action_t'(req.payload.action))
			cbsb_pkg::ACT_EXEC: begin
				word_d.dest_index = opnd;
				case (cbsb_pkg::group_t'(grp))
					cbsb_pkg::GRP_SHIFT: begin
						case (cbsb_pkg::shift_sel_t'(sel))
							cbsb_pkg::SH_RLC: begin
								cout = v[7];
								r    = {v[6:0], v[7]};
							end
							cbsb_pkg::SH_RRC: begin
								cout = v[0];
								r    = {v[0], v[7:1]};
							end
							cbsb_pkg::SH_RL: begin
								cout = v[7];
								r    = {v[6:0], flags_q.c};
							end
							cbsb_pkg::SH_RR: begin
								cout = v[0];
								r    = {flags_q.c, v[7:1]};
							end
							cbsb_pkg::SH_SLA: begin
								cout = v[7];
								r    = {v[6:0], 1'b0};
							end
							cbsb_pkg::SH_SRA: begin
								cout = v[0];
								r    = {v[7], v[7:1]};
							end
							cbsb_pkg::SH_SWAP: begin
								cout = 1'b0;
								r    = {v[3:0], v[7:4]};
							end
							default: begin
								cout = v[0];
								r    = {1'b0, v[7:1]};
							end
						endcase
						flags_d = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: cout};
					end
					cbsb_pkg::GRP_BIT: begin
						flags_d = '{z: ((v & mask) == 8'd0), n: 1'b0, h: 1'b1,
							c: flags_q.c};
					end
					cbsb_pkg::GRP_RES: r = v & ~mask;
					default:           r = v | mask;
				endcase
				word_d.result = r;
				// A bit test writes nothing back.
				if (cbsb_pkg::group_t'(grp) != cbsb_pkg::GRP_BIT) begin
					if (opnd == cbsb_pkg::OPND_MEM) begin
						word_d.mem_write = 1'b1;
					end else begin
						rf_d[opnd]       = r;
						word_d.reg_write = 1'b1;
					end
				end
			end
			cbsb_pkg::ACT_LOAD_REG: begin
				word_d.result     = req.payload.reg_value;
				word_d.dest_index = req.payload.reg_index;
				if (req.payload.reg_index != cbsb_pkg::OPND_MEM) begin
					rf_d[req.payload.reg_index] = req.payload.reg_value;
					word_d.reg_write            = 1'b1;
				end
			end
			cbsb_pkg::ACT_LOAD_FLG: begin
				flags_d       = cbsb_pkg::flags_t'(req.payload.reg_value[7:4]);
				word_d.result = {req.payload.reg_value[7:4], 4'd0};
			end
			default: begin
				word_d.result = 8'd0;
			end
		endcase

		// HL and flags as they stand after this word.
		word_d.mem_addr        = {rf_d[cbsb_pkg::OPND_H], rf_d[cbsb_pkg::OPND_L]};
		word_d.zero_flag       = flags_d.z;
		word_d.subtract_flag   = flags_d.n;
		word_d.half_carry_flag = flags_d.h;
		word_d.carry_flag      = flags_d.c;
	end

	// Register file and flags commit when a word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbsb_pkg::REG_COUNT; i++) begin
				rf_q[i] <= 8'd0;
			end
			flags_q <= '0;
		end else if (push) begin
			rf_q    <= rf_d;
			flags_q <= flags_d;
		end
	end

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end
	end

	// Output buffer words.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= word_d;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_q <= word_d;
			end else begin
				main_q <= word_d;
			end
		end
	end

	// The skid word is only ever held behind a main word.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid word held without a main word");

	// A taken request always leaves a word to offer in the next cycle.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> main_vld_q)
		else $error("request taken but no response offered");

	// A response never writes both a register and memory.
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.reg_write && rsp.payload.mem_write))
		else $error("register and memory write in one response");

	// A memory write always names the memory operand.
	a_mem_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.mem_write) |-> rsp.payload.dest_index == cbsb_pkg::OPND_MEM)
		else $error("memory write with a register destination");

	// The unused register slot is never written.
	a_slot_unused: assert property (@(posedge clk) disable iff (!arst_n)
		rf_q[cbsb_pkg::OPND_MEM] == 8'd0)
		else $error("unused register slot was written");

endmodule

// ===== bench/cbsb_checker.sv =====
// ----------------------------------------------------------------------------
// cbsb_checker: response checker for the CB-prefix shift and bit unit
// Watches both channels. Every request word taken by the unit runs through a
// private copy of the register file and flags, giving the response word that
// is due for it. Response words are compared field by field, in order.
// ----------------------------------------------------------------------------
module cbsb_checker
	import cbsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_word_t req_word,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_word_t rsp_word,
	output int        fail_count,
	output int        words_due
);

	logic [7:0] gpr [REG_COUNT];
	flags_t     cpu_flags;
	rsp_word_t  word_due [$];
	int         n_bad;

	// Applies one request word to the private state and returns its response.
	function automatic rsp_word_t execute_cb(req_word_t w);
		rsp_word_t  r;
		logic [7:0] v;
		logic [7:0] mask;
		logic [2:0] opnd;
		logic       cout;
		logic       wr;
		r = '0;
		case (action_t'(w.action))
			ACT_EXEC: begin
				opnd = w.opcode[2:0];
				mask = 8'd1 << w.opcode[5:3];
				v    = (opnd == OPND_MEM) ? w.mem_in : gpr[opnd];
				wr   = 1'b1;
				cout = 1'b0;
				case (group_t'(w.opcode[7:6]))
					GRP_SHIFT: begin
						case (shift_sel_t'(w.opcode[5:3]))
							SH_RLC: begin
								cout = v[7];
								v    = {v[6:0], v[7]};
							end
							SH_RRC: begin
								cout = v[0];
								v    = {v[0], v[7:1]};
							end
							SH_RL: begin
								cout = v[7];
								v    = {v[6:0], cpu_flags.c};
							end
							SH_RR: begin
								cout = v[0];
								v    = {cpu_flags.c, v[7:1]};
							end
							SH_SLA: begin
								cout = v[7];
								v    = {v[6:0], 1'b0};
							end
							SH_SRA: begin
								cout = v[0];
								v    = {v[7], v[7:1]};
							end
							SH_SWAP: begin
								cout = 1'b0;
								v    = {v[3:0], v[7:4]};
							end
							SH_SRL: begin
								cout = v[0];
								v    = {1'b0, v[7:1]};
							end
						endcase
						cpu_flags.z = (v == 8'h00);
						cpu_flags.n = 1'b0;
						cpu_flags.h = 1'b0;
						cpu_flags.c = cout;
					end
					// BIT only touches the flags and keeps the carry.
					GRP_BIT: begin
						cpu_flags.z = ~|(v & mask);
						cpu_flags.n = 1'b0;
						cpu_flags.h = 1'b1;
						wr          = 1'b0;
					end
					GRP_RES: v = v & ~mask;
					GRP_SET: v = v | mask;
				endcase
				r.result     = v;
				r.dest_index = opnd;
				if (wr) begin
					if (opnd == OPND_MEM) begin
						r.mem_write = 1'b1;
					end else begin
						gpr[opnd]   = v;
						r.reg_write = 1'b1;
					end
				end
			end
			// A load aimed at the memory slot writes nothing.
			ACT_LOAD_REG: begin
				r.result     = w.reg_value;
				r.dest_index = w.reg_index;
				if (w.reg_index != OPND_MEM) begin
					gpr[w.reg_index] = w.reg_value;
					r.reg_write      = 1'b1;
				end
			end
			ACT_LOAD_FLG: begin
				cpu_flags = w.reg_value[7:4];
				r.result  = {w.reg_value[7:4], 4'h0};
			end
			default: ;
		endcase
		r.mem_addr        = {gpr[OPND_H], gpr[OPND_L]};
		r.zero_flag       = cpu_flags.z;
		r.subtract_flag   = cpu_flags.n;
		r.half_carry_flag = cpu_flags.h;
		r.carry_flag      = cpu_flags.c;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			n_bad++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare taken response words, then predict for taken request words.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = 8'h00;
			cpu_flags = '0;
			word_due.delete();
			n_bad      = 0;
			fail_count <= 0;
			words_due  <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (word_due.size() == 0) begin
					n_bad++;
					$display("%0t: response word with none expected, expected nothing, got %h",
						$time, rsp_word);
				end else begin
					want = word_due.pop_front();
					check_field("result", 16'(want.result), 16'(rsp_word.result));
					check_field("dest_index", 16'(want.dest_index),
						16'(rsp_word.dest_index));
					check_field("reg_write", 16'(want.reg_write), 16'(rsp_word.reg_write));
					check_field("mem_write", 16'(want.mem_write), 16'(rsp_word.mem_write));
					check_field("mem_addr", want.mem_addr, rsp_word.mem_addr);
					check_field("zero_flag", 16'(want.zero_flag), 16'(rsp_word.zero_flag));
					check_field("subtract_flag", 16'(want.subtract_flag),
						16'(rsp_word.subtract_flag));
					check_field("half_carry_flag", 16'(want.half_carry_flag),
						16'(rsp_word.half_carry_flag));
					check_field("carry_flag", 16'(want.carry_flag),
						16'(rsp_word.carry_flag));
				end
			end
			if (req_valid && req_ready)
				word_due.push_back(execute_cb(req_word));
			fail_count <= n_bad;
			words_due  <= word_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the CB-prefix shift and bit unit
// Feeds a directed set of words covering every operation and corner, then
// random words with random gaps on the request side and random stalls on the
// response side. Checking is done by the checker placed beside the unit.
// ----------------------------------------------------------------------------
module tb;
	import cbsb_pkg::*;

	localparam int RANDOM_WORDS = 1850;
	localparam int MAX_WAIT     = 18;

	// Register operand codes not named in the package.
	localparam logic [2:0] OPND_B = 3'd0;
	localparam logic [2:0] OPND_C = 3'd1;
	localparam logic [2:0] OPND_D = 3'd2;
	localparam logic [2:0] OPND_E = 3'd3;
	localparam logic [2:0] OPND_A = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   words_due;
	int   tx_left = 0;
	bit   tx_calm = 1'b0;
	int   rx_left = 0;
	bit   rx_calm = 1'b0;

	cbsb_chan_if #(.payload_t(req_word_t)) req_if ();
	cbsb_chan_if #(.payload_t(rsp_word_t)) rsp_if ();

	cb_prefix_shift_bit_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	cbsb_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_if.valid),
		.req_ready  (req_if.ready),
		.req_word   (req_if.payload),
		.rsp_valid  (rsp_if.valid),
		.rsp_ready  (rsp_if.ready),
		.rsp_word   (rsp_if.payload),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Wait length for one word; runs of words now and then go without any wait.
	function automatic int draw_wait(inout int left, inout bit calm);
		if (left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			left = $urandom_range(16, 96);
		end
		left--;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [7:0] cb_op(group_t grp, logic [2:0] sel, logic [2:0] opnd);
		return {grp, sel, opnd};
	endfunction

	function automatic req_word_t make_word(action_t act, logic [7:0] op, logic [7:0] mem,
			logic [2:0] ridx, logic [7:0] rval);
		req_word_t w;
		w.action    = act;
		w.opcode    = op;
		w.mem_in    = mem;
		w.reg_index = ridx;
		w.reg_value = rval;
		return w;
	endfunction

	// Mostly opcode execution; values lean towards the all-zero and all-one bytes.
	function automatic req_word_t random_word();
		req_word_t w;
		int        pick;
		int        val_pick;
		pick     = $urandom_range(0, 99);
		val_pick = $urandom_range(0, 7);
		w.opcode    = 8'($urandom_range(0, 255));
		w.mem_in    = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		w.reg_index = 3'($urandom_range(0, 7));
		w.reg_value = (val_pick == 0) ? 8'h00 : (val_pick == 1) ? 8'hFF :
			8'($urandom_range(0, 255));
		if (pick < 70)
			w.action = ACT_EXEC;
		else if (pick < 85)
			w.action = ACT_LOAD_REG;
		else if (pick < 93)
			w.action = ACT_LOAD_FLG;
		else
			w.action = ACT_NONE;
		return w;
	endfunction

	// Offers one request word after a random gap and returns once it is taken.
	task automatic send_word(req_word_t w);
		int gap;
		gap = draw_wait(tx_left, tx_calm);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= w;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	// Holds off the request side until every response word has come back.
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	// Response side: random stall before each word is taken.
	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		forever begin
			stall = draw_wait(rx_left, rx_calm);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_if.valid);
		end
	end

	// Stimulus and verdict.
	initial begin
		req_word_t directed [$];
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Register loads with extreme values, and a load into the memory slot.
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_A, 8'hFF));
		directed.push_back(make_word(ACT_LOAD_REG, 8'hFF, 8'hFF, OPND_B, 8'h80));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_C, 8'h01));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_D, 8'h55));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_E, 8'hAA));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_H, 8'hFF));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_L, 8'h00));
		directed.push_back(make_word(ACT_LOAD_REG, 8'h00, 8'h00, OPND_MEM, 8'h3C));
		// Flag loads: low nibble of the value must be dropped.
		directed.push_back(make_word(ACT_LOAD_FLG, 8'h00, 8'h00, OPND_B, 8'hFF));
		directed.push_back(make_word(ACT_LOAD_FLG, 8'hFF, 8'hFF, OPND_A, 8'h00));
		// Every shift and rotate, on registers and on the memory byte.
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_RLC, OPND_A), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_RRC, OPND_C), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_RL, OPND_B), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_RR, OPND_MEM), 8'h01, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_SLA, OPND_D), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_SRA, OPND_E), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_SWAP, OPND_MEM), 8'hF0, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SHIFT, SH_SRL, OPND_L), 8'h00, 0, 0));
		// BIT writes nothing back; RES and SET on registers and memory.
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_BIT, 3'd7, OPND_A), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_BIT, 3'd0, OPND_MEM), 8'hFE, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_RES, 3'd7, OPND_H), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SET, 3'd0, OPND_L), 8'h00, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_RES, 3'd0, OPND_MEM), 8'hFF, 0, 0));
		directed.push_back(make_word(ACT_EXEC, cb_op(GRP_SET, 3'd7, OPND_MEM), 8'h00, 0, 0));
		// The unused action must leave everything alone.
		directed.push_back(make_word(ACT_NONE, 8'hFF, 8'hFF, 3'd7, 8'hFF));

		foreach (directed[i])
			send_word(directed[i]);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				drain();
			send_word(random_word());
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cbsb_pkg.sv
hdl/cbsb_chan_if.sv
hdl/cb_prefix_shift_bit_unit.sv
bench/cbsb_checker.sv
bench/tb.sv
